### rtl/json_string_unescape_utf8_defines.svh
// Assertion helpers for the JSON string unescaper.
`ifndef JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH

// same-cycle implication
`define JSU_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define JSU_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/jsu_pkg.sv
package jsu_pkg;

   localparam int MaxResults = 4;
   localparam int CntW       = $clog2(MaxResults + 1);

   localparam logic [7:0]  CtrlLimit = 8'h20;
   localparam logic [15:0] SurrHiLo  = 16'hd800;
   localparam logic [15:0] SurrHiHi  = 16'hdbff;
   localparam logic [15:0] SurrLoLo  = 16'hdc00;
   localparam logic [15:0] SurrLoHi  = 16'hdfff;
   localparam logic [20:0] PlaneOne  = 21'h10000;
   localparam logic [20:0] Lim1Byte  = 21'h7f;
   localparam logic [20:0] Lim2Byte  = 21'h7ff;
   localparam logic [20:0] Lim3Byte  = 21'hffff;
   localparam logic [7:0]  Lead2     = 8'hc0;
   localparam logic [7:0]  Lead3     = 8'he0;
   localparam logic [7:0]  Lead4     = 8'hf0;
   localparam logic [7:0]  ContMark  = 8'h80;

   typedef enum logic [3:0] {
      PH_IDLE   = 4'd0,
      PH_BODY   = 4'd1,
      PH_ESC    = 4'd2,
      PH_HEX1   = 4'd3,
      PH_WANTBS = 4'd4,
      PH_WANTU  = 4'd5,
      PH_HEX2   = 4'd6
   } phase_type;

   typedef enum logic [1:0] {
      KIND_BYTE = 2'd0,
      KIND_DONE = 2'd1,
      KIND_ERR  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE     = 3'd0,
      ERR_NO_QUOTE = 3'd1,
      ERR_CONTROL  = 3'd2,
      ERR_ESCAPE   = 3'd3,
      ERR_HEX      = 3'd4,
      ERR_UNPAIRED = 3'd5,
      ERR_PAIR     = 3'd6,
      ERR_UNTERM   = 3'd7
   } err_type;

   typedef struct packed {
      phase_type   phase;
      logic [1:0]  hex_count;
      logic [15:0] unit_accum;
      logic [9:0]  high_half;
   } parse_state_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      err_type    err;
   } result_type;

   typedef struct packed {
      logic [CntW-1:0]                count;
      result_type [MaxResults-1:0]    res;
   } step_type;

endpackage

### rtl/jsu_decode.sv
module jsu_decode import jsu_pkg::*; (
   input  parse_state_type cur,
   input  logic [7:0]      data_byte,
   input  logic            end_marker,
   output parse_state_type nxt,
   output step_type        step
);

   function automatic result_type mk(kind_type k, logic [7:0] b, err_type e);
      result_type r;
      r.kind = k;
      r.data = b;
      r.err  = e;
      return r;
   endfunction

   function automatic step_type one(kind_type k, logic [7:0] b, err_type e);
      step_type r;
      r        = '0;
      r.count  = CntW'(1);
      r.res[0] = mk(k, b, e);
      return r;
   endfunction

   // returns {valid, value}
   function automatic logic [4:0] hex_val(logic [7:0] c);
      logic [7:0] d;
      d = 8'h00;
      if (c inside {[8'h30:8'h39]}) begin
         d = c - 8'h30;
         return {1'b1, d[3:0]};
      end else if (c inside {[8'h61:8'h66]}) begin
         d = c - 8'h57;
         return {1'b1, d[3:0]};
      end else if (c inside {[8'h41:8'h46]}) begin
         d = c - 8'h37;
         return {1'b1, d[3:0]};
      end
      return 5'b0;
   endfunction

   function automatic step_type encode(logic [20:0] s);
      step_type r;
      r = '0;
      if (s <= Lim1Byte) begin
         r.count  = CntW'(1);
         r.res[0] = mk(KIND_BYTE, s[7:0], ERR_NONE);
      end else if (s <= Lim2Byte) begin
         r.count  = CntW'(2);
         r.res[0] = mk(KIND_BYTE, Lead2 | {3'b0, s[10:6]}, ERR_NONE);
         r.res[1] = mk(KIND_BYTE, ContMark | {2'b0, s[5:0]}, ERR_NONE);
      end else if (s <= Lim3Byte) begin
         r.count  = CntW'(3);
         r.res[0] = mk(KIND_BYTE, Lead3 | {4'b0, s[15:12]}, ERR_NONE);
         r.res[1] = mk(KIND_BYTE, ContMark | {2'b0, s[11:6]}, ERR_NONE);
         r.res[2] = mk(KIND_BYTE, ContMark | {2'b0, s[5:0]}, ERR_NONE);
      end else begin
         r.count  = CntW'(4);
         r.res[0] = mk(KIND_BYTE, Lead4 | {5'b0, s[20:18]}, ERR_NONE);
         r.res[1] = mk(KIND_BYTE, ContMark | {2'b0, s[17:12]}, ERR_NONE);
         r.res[2] = mk(KIND_BYTE, ContMark | {2'b0, s[11:6]}, ERR_NONE);
         r.res[3] = mk(KIND_BYTE, ContMark | {2'b0, s[5:0]}, ERR_NONE);
      end
      return r;
   endfunction

   logic [4:0]  hv;
   logic [15:0] acc_next;
   logic [20:0] pair_val;

   assign hv       = hex_val(data_byte);
   assign acc_next = {cur.unit_accum[11:0], hv[3:0]};
   assign pair_val = PlaneOne + {1'b0, cur.high_half, acc_next[9:0]};

   always_comb begin
      parse_state_type cleared;
      cleared       = '0;
      cleared.phase = PH_IDLE;
      nxt  = cur;
      step = '0;
      case (cur.phase)
         PH_BODY: begin
            if (end_marker) begin
               nxt  = cleared;
               step = one(KIND_ERR, 8'h00, ERR_UNTERM);
            end else if (data_byte == 8'h22) begin
               nxt.phase = PH_IDLE;
               step      = one(KIND_DONE, 8'h00, ERR_NONE);
            end else if (data_byte < CtrlLimit) begin
               nxt  = cleared;
               step = one(KIND_ERR, 8'h00, ERR_CONTROL);
            end else if (data_byte == 8'h5c) begin
               nxt.phase = PH_ESC;
            end else begin
               step = one(KIND_BYTE, data_byte, ERR_NONE);
            end
         end
         PH_ESC: begin
            nxt.phase = PH_BODY;
            if (end_marker) begin
               nxt  = cleared;
               step = one(KIND_ERR, 8'h00, ERR_UNTERM);
            end else begin
               case (data_byte)
                  8'h22:   step = one(KIND_BYTE, 8'h22, ERR_NONE);
                  8'h5c:   step = one(KIND_BYTE, 8'h5c, ERR_NONE);
                  8'h2f:   step = one(KIND_BYTE, 8'h2f, ERR_NONE);
                  8'h62:   step = one(KIND_BYTE, 8'h08, ERR_NONE);
                  8'h66:   step = one(KIND_BYTE, 8'h0c, ERR_NONE);
                  8'h6e:   step = one(KIND_BYTE, 8'h0a, ERR_NONE);
                  8'h72:   step = one(KIND_BYTE, 8'h0d, ERR_NONE);
                  8'h74:   step = one(KIND_BYTE, 8'h09, ERR_NONE);
                  8'h75: begin
                     nxt.phase      = PH_HEX1;
                     nxt.hex_count  = 2'd0;
                     nxt.unit_accum = 16'h0;
                  end
                  default: begin
                     nxt  = cleared;
                     step = one(KIND_ERR, 8'h00, ERR_ESCAPE);
                  end
               endcase
            end
         end
         PH_HEX1: begin
            if (end_marker || !hv[4]) begin
               nxt  = cleared;
               step = one(KIND_ERR, 8'h00, ERR_HEX);
            end else if (cur.hex_count != 2'd3) begin
               nxt.unit_accum = acc_next;
               nxt.hex_count  = cur.hex_count + 2'd1;
            end else if (acc_next >= SurrHiLo && acc_next <= SurrHiHi) begin
               nxt.hex_count  = 2'd0;
               nxt.high_half  = acc_next[9:0];
               nxt.unit_accum = 16'h0;
               nxt.phase      = PH_WANTBS;
            end else if (acc_next >= SurrLoLo && acc_next <= SurrLoHi) begin
               nxt  = cleared;
               step = one(KIND_ERR, 8'h00, ERR_UNPAIRED);
            end else begin
               nxt.phase      = PH_BODY;
               nxt.hex_count  = 2'd0;
               nxt.unit_accum = 16'h0;
               step           = encode({5'b0, acc_next});
            end
         end
         PH_WANTBS: begin
            if (end_marker || data_byte != 8'h5c) begin
               nxt  = cleared;
               step = one(KIND_ERR, 8'h00, ERR_UNPAIRED);
            end else begin
               nxt.phase = PH_WANTU;
            end
         end
         PH_WANTU: begin
            if (end_marker || data_byte != 8'h75) begin
               nxt  = cleared;
               step = one(KIND_ERR, 8'h00, ERR_UNPAIRED);
            end else begin
               nxt.phase      = PH_HEX2;
               nxt.hex_count  = 2'd0;
               nxt.unit_accum = 16'h0;
            end
         end
         PH_HEX2: begin
            if (end_marker) begin
               nxt  = cleared;
               step = one(KIND_ERR, 8'h00, ERR_UNPAIRED);
            end else if (!hv[4]) begin
               nxt  = cleared;
               step = one(KIND_ERR, 8'h00, ERR_PAIR);
            end else if (cur.hex_count != 2'd3) begin
               nxt.unit_accum = acc_next;
               nxt.hex_count  = cur.hex_count + 2'd1;
            end else if (acc_next < SurrLoLo || acc_next > SurrLoHi) begin
               nxt  = cleared;
               step = one(KIND_ERR, 8'h00, ERR_PAIR);
            end else begin
               nxt.phase      = PH_BODY;
               nxt.hex_count  = 2'd0;
               nxt.unit_accum = 16'h0;
               step           = encode(pair_val);
            end
         end
         default: begin
            if (end_marker || data_byte != 8'h22) begin
               nxt  = cleared;
               step = one(KIND_ERR, 8'h00, ERR_NO_QUOTE);
            end else begin
               nxt       = cleared;
               nxt.phase = PH_BODY;
            end
         end
      endcase
   end

endmodule

### rtl/json_string_unescape_utf8.sv
// JSON string unescaper: takes one quoted JSON string a byte per item, starting
// at the opening quote, and returns the decoded UTF-8 content bytes, then a
// done item at the closing quote, or a single error item that ends the string.
// Each input item is decoded in the cycle it is accepted; its results (up to
// four) land in a four-entry result buffer and leave one per cycle while
// rsp_ready is high; the first result appears in the cycle after acceptance.
// An item that yields no result leaves req_ready high; an item that yields
// one or more results (a \u escape may encode to two, three or four bytes)
// holds req_ready low until the last of them is being taken with rsp_ready high.
// rsp_last_of_run marks the final result of each input item.
`include "json_string_unescape_utf8_defines.svh"

module json_string_unescape_utf8 import jsu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_marker,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_item_kind,
   output logic [7:0] rsp_out_byte,
   output logic [2:0] rsp_error_code,
   output logic       rsp_last_of_run
);

   parse_state_type state_ff, state_in, state_dec;
   step_type        step;

   result_type [MaxResults-1:0] buf_ff, buf_in;
   logic [CntW-1:0]             cnt_ff, cnt_in;

   logic accept;
   logic pop;

   jsu_decode u_decode (
      .cur        (state_ff),
      .data_byte  (req_data_byte),
      .end_marker (req_end_marker),
      .nxt        (state_dec),
      .step       (step)
   );

   assign rsp_valid = (cnt_ff != '0);
   assign pop       = rsp_valid && rsp_ready;
   assign req_ready = (cnt_ff == '0) || ((cnt_ff == CntW'(1)) && rsp_ready);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      buf_in   = buf_ff;
      cnt_in   = cnt_ff;
      if (accept) begin
         state_in = state_dec;
         buf_in   = step.res;
         cnt_in   = step.count;
      end else if (pop) begin
         for (int i = 0; i < MaxResults - 1; i++) begin
            buf_in[i] = buf_ff[i+1];
         end
         buf_in[MaxResults-1] = '0;
         cnt_in = cnt_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
   end

   assign rsp_item_kind   = buf_ff[0].kind;
   assign rsp_out_byte    = buf_ff[0].data;
   assign rsp_error_code  = buf_ff[0].err;
   assign rsp_last_of_run = (cnt_ff == CntW'(1));

   `JSU_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_ff <= CntW'(MaxResults), "result count overflow")
   `JSU_ASSERT_NEXT(a_result_follows, accept && step.count != '0, rsp_valid, "result missing")
   `JSU_ASSERT_NOW(a_end_is_last, rsp_valid && rsp_item_kind != KIND_BYTE, rsp_last_of_run, "done or error not last")
   `JSU_ASSERT_NOW(a_err_code, rsp_valid && rsp_item_kind == KIND_ERR, rsp_error_code != ERR_NONE, "error without code")
   `JSU_ASSERT_NEXT(a_err_to_idle, accept && step.res[0].kind == KIND_ERR, state_ff.phase == PH_IDLE, "no idle after error")

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import jsu_pkg::*;

   localparam int         CycleLimit = 60000;
   localparam int         TextItems  = 320;
   localparam logic [7:0] ChQuote    = 8'h22;
   localparam logic [7:0] ChBslash   = 8'h5c;

   typedef struct {
      logic [7:0] ch;
      logic       eoi;
      logic       drain;
   } text_byte_type;

   typedef struct {
      kind_type   kind;
      logic [7:0] data;
      err_type    err;
      logic       last;
   } decoded_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_end_marker = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [1:0] rsp_item_kind;
   logic [7:0] rsp_out_byte;
   logic [2:0] rsp_error_code;
   logic       rsp_last_of_run;

   text_byte_type text_q[$];
   decoded_type   decoded_q[$];
   decoded_type   step_out[$];
   decoded_type   want;
   logic          drain_next = 1'b0;
   int            accepted_cnt = 0;
   int            fail_cnt = 0;
   int            cycle_cnt = 0;
   logic          calm;

   // decoder state
   phase_type   st_phase = PH_IDLE;
   logic [1:0]  hex_cnt = 2'd0;
   logic [15:0] unit_acc = 16'd0;
   logic [9:0]  hi_half = 10'd0;

   json_string_unescape_utf8 DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_end_marker  (req_end_marker),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_item_kind   (rsp_item_kind),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_error_code  (rsp_error_code),
      .rsp_last_of_run (rsp_last_of_run)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // neither side idles at random during this window
   assign calm = (accepted_cnt >= 120 && accepted_cnt < 200);

   task automatic emit(input kind_type k, input logic [7:0] b, input err_type e);
      decoded_type r;
      r.kind = k;
      r.data = b;
      r.err  = e;
      r.last = 1'b0;
      step_out = {step_out, r};
   endtask

   task automatic fail_to_idle(input err_type e);
      st_phase = PH_IDLE;
      hex_cnt  = 2'd0;
      unit_acc = 16'd0;
      hi_half  = 10'd0;
      emit(KIND_ERR, 8'h00, e);
   endtask

   task automatic emit_utf8(input logic [20:0] cp);
      if (cp <= Lim1Byte) begin
         emit(KIND_BYTE, cp[7:0], ERR_NONE);
      end else if (cp <= Lim2Byte) begin
         emit(KIND_BYTE, Lead2 | {3'd0, cp[10:6]}, ERR_NONE);
         emit(KIND_BYTE, ContMark | {2'd0, cp[5:0]}, ERR_NONE);
      end else if (cp <= Lim3Byte) begin
         emit(KIND_BYTE, Lead3 | {4'd0, cp[15:12]}, ERR_NONE);
         emit(KIND_BYTE, ContMark | {2'd0, cp[11:6]}, ERR_NONE);
         emit(KIND_BYTE, ContMark | {2'd0, cp[5:0]}, ERR_NONE);
      end else begin
         emit(KIND_BYTE, Lead4 | {5'd0, cp[20:18]}, ERR_NONE);
         emit(KIND_BYTE, ContMark | {2'd0, cp[17:12]}, ERR_NONE);
         emit(KIND_BYTE, ContMark | {2'd0, cp[11:6]}, ERR_NONE);
         emit(KIND_BYTE, ContMark | {2'd0, cp[5:0]}, ERR_NONE);
      end
      st_phase = PH_BODY;
      hex_cnt  = 2'd0;
      unit_acc = 16'd0;
   endtask

   task automatic unescape_step(input logic [7:0] c, input logic eoi);
      logic        is_hex;
      logic [3:0]  nib;
      logic [15:0] acc_next;
      decoded_type r;
      step_out.delete();
      if (c >= "0" && c <= "9") begin
         is_hex = 1'b1;
         nib    = c[3:0];
      end else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
         is_hex = 1'b1;
         nib    = c[3:0] + 4'd9;
      end else begin
         is_hex = 1'b0;
         nib    = 4'd0;
      end
      acc_next = {unit_acc[11:0], nib};
      case (st_phase)
         PH_BODY: begin
            if (eoi) fail_to_idle(ERR_UNTERM);
            else if (c == ChQuote) begin
               st_phase = PH_IDLE;
               emit(KIND_DONE, 8'h00, ERR_NONE);
            end else if (c < CtrlLimit) fail_to_idle(ERR_CONTROL);
            else if (c == ChBslash) st_phase = PH_ESC;
            else emit(KIND_BYTE, c, ERR_NONE);
         end
         PH_ESC: begin
            if (eoi) fail_to_idle(ERR_UNTERM);
            else begin
               st_phase = PH_BODY;
               case (c)
                  "\"": emit(KIND_BYTE, 8'h22, ERR_NONE);
                  "\\": emit(KIND_BYTE, 8'h5c, ERR_NONE);
                  "/":  emit(KIND_BYTE, 8'h2f, ERR_NONE);
                  "b":  emit(KIND_BYTE, 8'h08, ERR_NONE);
                  "f":  emit(KIND_BYTE, 8'h0c, ERR_NONE);
                  "n":  emit(KIND_BYTE, 8'h0a, ERR_NONE);
                  "r":  emit(KIND_BYTE, 8'h0d, ERR_NONE);
                  "t":  emit(KIND_BYTE, 8'h09, ERR_NONE);
                  "u": begin
                     st_phase = PH_HEX1;
                     hex_cnt  = 2'd0;
                     unit_acc = 16'd0;
                  end
                  default: fail_to_idle(ERR_ESCAPE);
               endcase
            end
         end
         PH_HEX1: begin
            if (eoi || !is_hex) fail_to_idle(ERR_HEX);
            else if (hex_cnt != 2'd3) begin
               unit_acc = acc_next;
               hex_cnt  = hex_cnt + 2'd1;
            end else begin
               hex_cnt = 2'd0;
               if (acc_next >= SurrHiLo && acc_next <= SurrHiHi) begin
                  hi_half  = acc_next[9:0];  // high surrogate base is 1k aligned
                  unit_acc = 16'd0;
                  st_phase = PH_WANTBS;
               end else if (acc_next >= SurrLoLo && acc_next <= SurrLoHi) begin
                  fail_to_idle(ERR_UNPAIRED);
               end else begin
                  emit_utf8({5'd0, acc_next});
               end
            end
         end
         PH_WANTBS: begin
            if (eoi || c != ChBslash) fail_to_idle(ERR_UNPAIRED);
            else st_phase = PH_WANTU;
         end
         PH_WANTU: begin
            if (eoi || c != "u") fail_to_idle(ERR_UNPAIRED);
            else begin
               st_phase = PH_HEX2;
               hex_cnt  = 2'd0;
               unit_acc = 16'd0;
            end
         end
         PH_HEX2: begin
            if (eoi) fail_to_idle(ERR_UNPAIRED);
            else if (!is_hex) fail_to_idle(ERR_PAIR);
            else if (hex_cnt != 2'd3) begin
               unit_acc = acc_next;
               hex_cnt  = hex_cnt + 2'd1;
            end else if (acc_next < SurrLoLo || acc_next > SurrLoHi) begin
               fail_to_idle(ERR_PAIR);
            end else begin
               emit_utf8(PlaneOne + {1'b0, hi_half, acc_next[9:0]});
            end
         end
         default: begin
            if (eoi || c != ChQuote) fail_to_idle(ERR_NO_QUOTE);
            else begin
               st_phase = PH_BODY;
               hex_cnt  = 2'd0;
               unit_acc = 16'd0;
               hi_half  = 10'd0;
            end
         end
      endcase
      foreach (step_out[i]) begin
         r         = step_out[i];
         r.last    = (i == step_out.size() - 1);
         decoded_q = {decoded_q, r};
      end
   endtask

   // stimulus helpers
   task automatic push_byte(input logic [7:0] b);
      text_byte_type t;
      t.ch       = b;
      t.eoi      = 1'b0;
      t.drain    = drain_next;
      drain_next = 1'b0;
      text_q     = {text_q, t};
   endtask

   task automatic push_end();
      text_byte_type t;
      t.ch       = 8'($urandom_range(255));
      t.eoi      = 1'b1;
      t.drain    = drain_next;
      drain_next = 1'b0;
      text_q     = {text_q, t};
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) return 8'h30 + n;
      return ($urandom_range(1) ? 8'h41 : 8'h61) + n - 8'd10;
   endfunction

   function automatic logic [7:0] non_hex_byte();
      logic [7:0] b;
      b = 8'($urandom_range(255));
      while ((b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F"))
         b = 8'($urandom_range(255));
      return b;
   endfunction

   task automatic push_hex(input logic [15:0] v, input int ndig);
      for (int d = 0; d < ndig; d++) push_byte(hex_char(v[15 - 4 * d -: 4]));
   endtask

   task automatic push_unit(input logic [15:0] v);
      push_byte(ChBslash);
      push_byte("u");
      push_hex(v, 4);
   endtask

   task automatic gen_string();
      int          ntok;
      int          pick;
      int          k;
      logic [7:0]  b;
      logic [15:0] v;
      logic [15:0] lo;
      logic [7:0]  tail [6];
      pick = $urandom_range(99);
      if (pick < 3) begin
         b = 8'($urandom_range(255));
         push_byte(b == ChQuote ? 8'h00 : b);
         return;
      end
      if (pick < 5) begin
         push_end();
         return;
      end
      push_byte(ChQuote);
      ntok = $urandom_range(6);
      for (int i = 0; i < ntok; i++) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            b = 8'($urandom_range(255, 32));
            push_byte((b == ChQuote || b == ChBslash) ? 8'h41 : b);
         end else if (pick < 55) begin
            push_byte(ChBslash);
            case ($urandom_range(7))
               0: push_byte("\"");
               1: push_byte("\\");
               2: push_byte("/");
               3: push_byte("b");
               4: push_byte("f");
               5: push_byte("n");
               6: push_byte("r");
               default: push_byte("t");
            endcase
         end else if (pick < 72) begin
            case ($urandom_range(2))
               0: v = 16'($urandom_range(16'h7f));
               1: v = 16'($urandom_range(16'h7ff, 16'h80));
               default: v = 16'($urandom_range(16'hffff, 16'h800));
            endcase
            if (v >= 16'hd800 && v <= 16'hdfff) v = v ^ 16'h2000;
            push_unit(v);
         end else if (pick < 92) begin
            push_unit(16'($urandom_range(16'hdbff, 16'hd800)));
            push_unit(16'($urandom_range(16'hdfff, 16'hdc00)));
         end else begin
            // broken sequences, each one ends the string
            case ($urandom_range(9))
               0: push_byte(8'($urandom_range(31)));
               1: begin
                  push_byte(ChBslash);
                  b = 8'($urandom_range(255));
                  while (b == "\"" || b == "\\" || b == "/" || b == "b" || b == "f" ||
                         b == "n" || b == "r" || b == "t" || b == "u")
                     b = 8'($urandom_range(255));
                  push_byte(b);
               end
               2: begin
                  push_byte(ChBslash);
                  push_byte("u");
                  push_hex(16'($urandom_range(16'hffff)), $urandom_range(3));
                  push_byte(non_hex_byte());
               end
               3: push_unit(16'($urandom_range(16'hdfff, 16'hdc00)));
               4: begin
                  push_unit(16'($urandom_range(16'hdbff, 16'hd800)));
                  b = 8'($urandom_range(255));
                  if ($urandom_range(1)) begin
                     push_byte(b == ChBslash ? 8'h00 : b);
                  end else begin
                     push_byte(ChBslash);
                     push_byte(b == "u" ? 8'h55 : b);
                  end
               end
               5: begin
                  push_unit(16'($urandom_range(16'hdbff, 16'hd800)));
                  push_byte(ChBslash);
                  push_byte("u");
                  push_hex(16'($urandom_range(16'hffff)), $urandom_range(3));
                  push_byte(non_hex_byte());
               end
               6: begin
                  push_unit(16'($urandom_range(16'hdbff, 16'hd800)));
                  v = 16'($urandom_range(16'hffff));
                  if (v >= 16'hdc00 && v <= 16'hdfff) v = v ^ 16'h4000;
                  push_unit(v);
               end
               7: begin
                  push_unit(16'($urandom_range(16'hdbff, 16'hd800)));
                  lo      = 16'($urandom_range(16'hdfff, 16'hdc00));
                  tail[0] = ChBslash;
                  tail[1] = "u";
                  for (int d = 0; d < 4; d++) tail[2 + d] = hex_char(lo[15 - 4 * d -: 4]);
                  k = $urandom_range(5);
                  for (int d = 0; d < k; d++) push_byte(tail[d]);
                  push_end();
               end
               8: begin
                  push_byte(ChBslash);
                  push_byte("u");
                  push_hex(16'($urandom_range(16'hffff)), $urandom_range(3));
                  push_end();
               end
               default: begin
                  if ($urandom_range(1)) push_byte(ChBslash);
                  push_end();
               end
            endcase
            return;
         end
      end
      pick = $urandom_range(99);
      if (pick < 90) push_byte(ChQuote);
      else if (pick < 95) push_end();
      else push_byte(8'($urandom_range(31)));
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            unescape_step(req_data_byte, req_end_marker);
            accepted_cnt <= accepted_cnt + 1;
         end
         if (text_q.size() != 0 && (calm || $urandom_range(99) >= 7) &&
             !(text_q[0].drain && decoded_q.size() != 0)) begin
            req_valid      <= 1'b1;
            req_data_byte  <= text_q[0].ch;
            req_end_marker <= text_q[0].eoi;
            text_q.delete(0);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= 7);
      if (!reset && rsp_valid && rsp_ready) begin
         if (decoded_q.size() == 0) begin
            $display("%0t: unexpected item: kind=%0d byte=%h err=%0d last=%b", $time,
                     rsp_item_kind, rsp_out_byte, rsp_error_code, rsp_last_of_run);
            fail_cnt++;
         end else begin
            want = decoded_q.pop_front();
            if (rsp_item_kind !== want.kind || rsp_out_byte !== want.data ||
                rsp_error_code !== want.err || rsp_last_of_run !== want.last) begin
               $display("%0t: mismatch: expected kind=%0d byte=%h err=%0d last=%b", $time,
                        want.kind, want.data, want.err, want.last);
               $display("%0t:           actual kind=%0d byte=%h err=%0d last=%b", $time,
                        rsp_item_kind, rsp_out_byte, rsp_error_code, rsp_last_of_run);
               fail_cnt++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CycleLimit) begin
         $display("%0t: timeout, %0d items still expected", $time, decoded_q.size());
         $display("FAIL json_string_unescape_utf8");
         $finish;
      end
   end

   initial begin
      // directed: idle errors, plain bytes, control byte, escape errors,
      // largest surrogate pair followed by a simple escape
      push_end();
      push_byte(8'h00);
      push_byte(ChQuote);
      push_byte(8'h20);
      push_byte(8'h7f);
      push_byte(8'hff);
      push_byte(8'h1f);
      push_byte(ChQuote);
      push_byte(ChBslash);
      push_byte("x");
      push_byte(ChQuote);
      push_byte(ChBslash);
      push_end();
      push_byte(ChQuote);
      push_unit(16'hdbff);
      push_unit(16'hdfff);
      push_byte(ChBslash);
      push_byte("n");
      push_byte(ChQuote);
      // random strings; the first one waits for everything before it
      drain_next = 1'b1;
      while (text_q.size() < TextItems) begin
         if ($urandom_range(99) < 4) drain_next = 1'b1;
         gen_string();
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      while (text_q.size() != 0 || req_valid || decoded_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_cnt == 0) $display("PASS json_string_unescape_utf8");
      else $display("FAIL json_string_unescape_utf8");
      $finish;
   end

endmodule

### files.f
+incdir+rtl
rtl/jsu_pkg.sv
rtl/jsu_decode.sv
rtl/json_string_unescape_utf8.sv
dv/testbench.sv
